// ----- rtl/array_double_ended_queue_assert.svh -----
// Assertion macros shared by the deque checker.
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("deque assertion failed");

`endif

// ----- rtl/adq_pkg.sv -----
// Shared constants, codes and command types for the array deque.
package adq_pkg;

	localparam int DEPTH   = 16;
	localparam int AW      = $clog2(DEPTH);
	localparam int IW      = AW + 1;
	localparam int DATA_W  = 32;
	localparam int CAP_W   = 5;
	localparam int ACT_W   = 2;
	localparam int ST_W    = 2;
	localparam int TDATA_W = 40;

	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 2'd3;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_NOROOM = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;

	typedef struct packed {
		logic accept;
		logic exec;
		logic load_out;
	} adq_cmd_t;

endpackage

// ----- rtl/adq_ctrl.sv -----
// Controller state machine: sequences accept, execute and result load.
module adq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output adq_pkg::adq_cmd_t cmd
);
	import adq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready     = (state_q == S_IDLE);
	assign m_tvalid     = out_valid_q;
	assign out_free     = !out_valid_q || m_tready;
	assign cmd.accept   = (state_q == S_IDLE) && s_tvalid;
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.load_out = (state_q == S_RESP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The output register holds a finished result while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/adq_dpath.sv -----
// Datapath: indices, capacity register, slot memory and result registers.
module adq_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  adq_pkg::adq_cmd_t            cmd,
	input  logic                         cfg_write,
	input  logic [adq_pkg::CAP_W-1:0]    cfg_data,
	input  logic [adq_pkg::TDATA_W-1:0]  s_tdata,
	output logic [adq_pkg::TDATA_W-1:0]  m_tdata
);
	import adq_pkg::*;

	logic [DATA_W-1:0]        slots [DEPTH];
	logic [CAP_W-1:0]         cap_q;
	logic signed [IW-1:0]     front_q;
	logic signed [IW-1:0]     rear_q;
	logic [ACT_W-1:0]         act_q;
	logic [DATA_W-1:0]        val_q;
	logic [ST_W-1:0]          st_q;
	logic [DATA_W-1:0]        rd_q;
	logic [ST_W-1:0]          st_out_q;
	logic [DATA_W-1:0]        pop_out_q;

	logic signed [IW-1:0]     last_s;
	logic                     empty;
	logic                     rear_full;
	logic [ST_W-1:0]          st_n;
	logic signed [IW-1:0]     addr_s;
	logic                     wr_en;
	logic                     is_pop;

	// The effective capacity is clamped to one slot at least and the array size at most.
	always_comb begin
		if (cap_q == '0) begin
			last_s = '0;
		end else if (int'(cap_q) > DEPTH) begin
			last_s = IW'(DEPTH - 1);
		end else begin
			last_s = IW'(int'(cap_q) - 1);
		end
	end

	assign empty     = (front_q >= rear_q);
	assign rear_full = (rear_q >= last_s);
	assign is_pop    = (act_q == ACT_POP_FRONT) || (act_q == ACT_POP_REAR);

	always_comb begin
		st_n   = ST_DONE;
		addr_s = rear_q;
		wr_en  = 1'b0;
		case (act_q)
			ACT_PUSH_REAR: begin
				addr_s = rear_q + IW'(1);
				if (rear_full) st_n = ST_NOROOM;
				else wr_en = 1'b1;
			end
			ACT_PUSH_FRONT: begin
				addr_s = front_q;
				if (front_q < 0) st_n = ST_NOROOM;
				else wr_en = 1'b1;
			end
			ACT_POP_FRONT: begin
				addr_s = front_q + IW'(1);
				if (empty) st_n = ST_EMPTY;
			end
			ACT_POP_REAR: begin
				addr_s = rear_q;
				if (empty) st_n = ST_EMPTY;
			end
			default: begin
				st_n = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_W'(DEPTH);
			front_q <= '1;
			rear_q  <= '1;
		end else begin
			if (cfg_write) cap_q <= cfg_data;
			if (cmd.exec && st_n == ST_DONE) begin
				case (act_q)
					ACT_PUSH_REAR:  rear_q  <= rear_q + IW'(1);
					ACT_PUSH_FRONT: front_q <= front_q - IW'(1);
					ACT_POP_FRONT:  front_q <= front_q + IW'(1);
					ACT_POP_REAR:   rear_q  <= rear_q - IW'(1);
					default:        rear_q  <= rear_q;
				endcase
			end
		end
	end

	// Every slot touched by a successful operation lies in 0..DEPTH-1.
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) slots[addr_s[AW-1:0]] <= val_q;
		if (cmd.exec) rd_q <= slots[addr_s[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= s_tdata[ACT_W-1:0];
			val_q <= s_tdata[ACT_W +: DATA_W];
		end
		if (cmd.exec) st_q <= st_n;
		if (cmd.load_out) begin
			st_out_q <= st_q;
			if (st_q == ST_EMPTY) pop_out_q <= '1;
			else if (is_pop) pop_out_q <= rd_q;
			else pop_out_q <= '0;
		end
	end

	assign m_tdata = {(TDATA_W - ST_W - DATA_W)'(0), pop_out_q, st_out_q};

endmodule

// ----- rtl/array_double_ended_queue.sv -----
// Linear array deque over 16 slots of 32 bits with front and rear indices that start at
// minus one. Each request goes from acceptance to a result in the output register through
// accept, execute with one slot access, and load the result; a new request is taken only
// once the controller is back in idle, and a stalled result holds the controller in its final
// state until the output register frees. capacity resets to 16.
module array_double_ended_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [adq_pkg::TDATA_W-1:0] s_tdata,  // action[1:0], push_value[33:2], zero pad
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [adq_pkg::TDATA_W-1:0] m_tdata,  // status[1:0], pop_value[33:2], zero pad
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [adq_pkg::CAP_W-1:0]   cfg_data
);
	import adq_pkg::*;

	adq_cmd_t cmd;

	assign cfg_ready = 1'b1;

	adq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	adq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- rtl/adq_checker.sv -----
// Port-level checker for the array deque, bound to the top level.
`include "array_double_ended_queue_assert.svh"

module adq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [adq_pkg::TDATA_W-1:0] m_tdata
);
	import adq_pkg::*;

	logic [ST_W-1:0]   status;
	logic [DATA_W-1:0] pop_value;

	assign status    = m_tdata[ST_W-1:0];
	assign pop_value = m_tdata[ST_W +: DATA_W];

	`ADQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ADQ_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, status <= ST_EMPTY)
	`ADQ_ASSERT_NOW(a_empty_value, clk, arst_n, m_tvalid && status == ST_EMPTY, pop_value == '1)
	`ADQ_ASSERT_NOW(a_noroom_value, clk, arst_n, m_tvalid && status == ST_NOROOM, pop_value == '0)
	`ADQ_ASSERT_NEXT(a_busy_after, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind array_double_ended_queue adq_checker u_adq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the array deque: random and directed requests against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import adq_pkg::*;

	localparam int PHASES      = 9;
	localparam int IDLE_LIMIT  = 2000;
	localparam int LONG_HOLD   = 80;
	localparam int LONG_AT     = 300;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		logic [ACT_W-1:0]  action;
		logic [DATA_W-1:0] value;
	} request_t;

	typedef struct {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] pop_value;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data = '0;

	// Predictor state: slot contents, both indices and the capacity register.
	logic [DATA_W-1:0]    slot_mem [DEPTH];
	int                   front_idx = -1;
	int                   rear_idx = -1;
	logic [CAP_W-1:0]     cap_reg = 5'd16;

	request_t             request_queue [$];
	outcome_t             expected_outcomes [$];
	request_t             offered;
	outcome_t             predicted;
	outcome_t             oldest;
	int                   send_gap = 0;
	int                   recv_hold = 0;
	bit                   send_idle = 1'b1;
	bit                   recv_idle = 1'b1;
	bit                   long_hold_done = 1'b0;
	int                   results_seen = 0;
	int                   fail_count = 0;
	int                   quiet_cycles = 0;

	array_double_ended_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void apply_request(input request_t rq, output outcome_t oc);
		int  limit;
		bit  empty;
		limit = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
		empty = front_idx >= rear_idx;
		oc.status = ST_DONE;
		oc.pop_value = '0;
		case (rq.action)
			ACT_PUSH_REAR: begin
				if (rear_idx >= limit - 1) begin
					oc.status = ST_NOROOM;
				end else begin
					rear_idx++;
					slot_mem[rear_idx] = rq.value;
				end
			end
			ACT_PUSH_FRONT: begin
				if (front_idx < 0) begin
					oc.status = ST_NOROOM;
				end else begin
					slot_mem[front_idx] = rq.value;
					front_idx--;
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					oc.status = ST_EMPTY;
					oc.pop_value = '1;
				end else begin
					front_idx++;
					oc.pop_value = slot_mem[front_idx];
				end
			end
			ACT_POP_REAR: begin
				if (empty) begin
					oc.status = ST_EMPTY;
					oc.pop_value = '1;
				end else begin
					oc.pop_value = slot_mem[rear_idx];
					rear_idx--;
				end
			end
			default: begin
				oc.status = ST_DONE;
			end
		endcase
	endfunction

	// Sender: predicts each request as it is accepted, then offers the next one, after a random gap when idles are on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_request(offered, predicted);
				expected_outcomes.push_back(predicted);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					offered = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(TDATA_W - DATA_W - ACT_W){1'b0}}, offered.value, offered.action};
					send_gap <= send_idle ? $urandom_range(0, 4) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result against the oldest prediction and stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_outcomes.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("unexpected result: status %0d value %h",
							m_tdata[1:0], m_tdata[33:2]);
					fail_count++;
				end else begin
					oldest = expected_outcomes.pop_front();
					if (m_tdata[1:0] !== oldest.status || m_tdata[33:2] !== oldest.pop_value) begin
						if (fail_count < REPORT_MAX)
							$display("mismatch: status exp %0d got %0d, value exp %h got %h",
								oldest.status, m_tdata[1:0], oldest.pop_value, m_tdata[33:2]);
						fail_count++;
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				// One long hold lets the block back up and stall its input side.
				if (results_seen >= LONG_AT && !long_hold_done) begin
					long_hold_done <= 1'b1;
					recv_hold <= LONG_HOLD;
					m_tready <= 1'b0;
				end else if (recv_idle && $urandom_range(0, 1) == 1) begin
					recv_hold <= $urandom_range(0, 3);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic add_request(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
		request_t rq;
		rq.action = act;
		rq.value = val;
		request_queue.push_back(rq);
	endtask

	task automatic wait_drained();
		while (request_queue.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = cap;
	endtask

	initial begin
		int                caps [PHASES];
		int                counts [PHASES];
		int                push_pct [PHASES];
		bit                idle_on [PHASES];
		int                pick;
		logic [DATA_W-1:0] word;
		logic [ACT_W-1:0]  act;

		// The first phase runs at the reset capacity; capacity 3 then lands below the fill.
		caps     = '{16, 3, 1, 0, 2, 31, 17, 16, 0};
		counts   = '{200, 150, 150, 150, 150, 200, 150, 150, 150};
		push_pct = '{75, 50, 50, 55, 50, 80, 35, 60, 50};
		idle_on  = '{1, 1, 0, 1, 1, 1, 0, 1, 1};
		caps[PHASES-1] = $urandom_range(0, 31);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				write_capacity(CAP_W'(caps[p]));
			end
			send_idle = idle_on[p];
			recv_idle = idle_on[p];
			if (p == 0) begin
				add_request(ACT_POP_FRONT, 32'h1234_5678);
				add_request(ACT_POP_REAR, 32'hFFFF_FFFF);
				add_request(ACT_PUSH_FRONT, 32'h0000_0001);
				add_request(ACT_PUSH_REAR, 32'h8000_0000);
				add_request(ACT_PUSH_REAR, 32'h7FFF_FFFF);
				add_request(ACT_PUSH_REAR, 32'h0000_0000);
				add_request(ACT_PUSH_REAR, 32'hFFFF_FFFF);
				add_request(ACT_POP_FRONT, 32'h0000_0000);
				add_request(ACT_PUSH_FRONT, 32'hA5A5_A5A5);
				add_request(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
				add_request(ACT_POP_REAR, 32'h0000_0000);
				add_request(ACT_POP_FRONT, 32'h0000_0000);
				add_request(ACT_POP_FRONT, 32'h0000_0000);
				add_request(ACT_POP_REAR, 32'h0000_0000);
				add_request(ACT_POP_FRONT, 32'h0000_0000);
				add_request(ACT_PUSH_REAR, 32'h5555_5555);
				add_request(ACT_POP_REAR, 32'h0000_0000);
			end
			for (int i = 0; i < counts[p]; i++) begin
				pick = $urandom_range(0, 99);
				word = $urandom;
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0: word = 32'h8000_0000;
						1: word = 32'h7FFF_FFFF;
						2: word = 32'h0000_0000;
						default: word = 32'hFFFF_FFFF;
					endcase
				end
				if (pick < push_pct[p])
					act = ($urandom_range(0, 1) == 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
				else
					act = ($urandom_range(0, 1) == 1) ? ACT_POP_REAR : ACT_POP_FRONT;
				add_request(act, word);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_outcomes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/adq_pkg.sv
rtl/adq_ctrl.sv
rtl/adq_dpath.sv
rtl/array_double_ended_queue.sv
rtl/adq_checker.sv
tb/sv/tb_top.sv
